@@ rtl/dominant_edge_direction_core_assert.svh @@
// Assertion macros used by ded_checker.
`ifndef DOMINANT_EDGE_DIRECTION_CORE_ASSERT_SVH
`define DOMINANT_EDGE_DIRECTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ded assertion failed");

// Next-cycle implication, disabled during reset.
`define DED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ded assertion failed");

`endif

@@ rtl/ded_pkg.sv @@
// ----------------------------------------------------------------------------
// ded_pkg
// Shared types, constants and constant tables of the edge direction core.
// ----------------------------------------------------------------------------
package ded_pkg;

    localparam int VEC_FRAC     = 44;
    localparam int ANG_FRAC     = 56;
    localparam int CORDIC_STEPS = 48;
    localparam int STEP_W       = 6;
    localparam int HIST_BINS    = 180;
    localparam int HALF_TURN    = 180;
    localparam int BIN_W        = 8;
    localparam int DEG_W        = 7;
    localparam int DEG_MAX      = 90;
    localparam int ZW           = 59;
    localparam int TW           = 66;
    localparam int THR_N        = 128;
    localparam int SERIES_FRAC  = 60;
    localparam int CNT_W        = 8;

    typedef logic [63:0] atan_tab_t [CORDIC_STEPS];
    typedef logic [TW-1:0] thr_tab_t [THR_N];

    typedef struct packed {
        logic             accept;
        logic             load_edge;
        logic             sel_close;
        logic             prep;
        logic             iter;
        logic             scale;
        logic             search;
        logic             bin_rd;
        logic             acc_wr;
        logic             scan;
        logic             out_load;
        logic [CNT_W-1:0] cnt;
    } ded_cmd_t;

    typedef struct packed {
        logic have_vertex;
        logic last;
        logic zero_edge;
        logic out_free;
    } ded_stat_t;

    // Shift-subtract divide, elaboration use only.
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) scaled by 2^60, Taylor series.
    function automatic logic signed [63:0] series_pow2(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 e;
        sum = '0;
        for (int n = 0; n < 40; n++) begin
            e = SERIES_FRAC - i * (2 * n + 1);
            if (e >= 0) begin
                term = $signed(udiv(64'd1 << e, 64'(2 * n + 1)));
                sum  = (n % 2 == 1) ? sum - term : sum + term;
            end
        end
        return sum;
    endfunction

    // atan(1/m) scaled by 2^60.
    function automatic logic signed [63:0] series_inv(input logic [63:0] m);
        logic [63:0]        p;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        p   = udiv(64'd1 << SERIES_FRAC, m);
        sum = '0;
        for (int n = 0; n < 40; n++) begin
            if (p != 0) begin
                term = $signed(udiv(p, 64'(2 * n + 1)));
                sum  = (n % 2 == 1) ? sum - term : sum + term;
                p    = udiv(p, m * m);
            end
        end
        return sum;
    endfunction

    function automatic atan_tab_t build_atan();
        atan_tab_t          t;
        logic signed [63:0] qp;
        qp   = 4 * series_inv(64'd5) - series_inv(64'd239);
        t[0] = (qp + 64'sd8) >>> 4;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            t[i] = (series_pow2(i) + 64'sd8) >>> 4;
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();

    // Degree k is reached once 90*z >= (2k-1)*atan(1).
    function automatic thr_tab_t build_thr();
        thr_tab_t t;
        for (int k = 0; k < THR_N; k++) begin
            if (k == 0) begin
                t[k] = '0;
            end else if (k <= DEG_MAX) begin
                t[k] = TW'(ATAN_TAB[0]) * TW'(2 * k - 1);
            end else begin
                t[k] = '1;
            end
        end
        return t;
    endfunction

    localparam thr_tab_t THR_TAB = build_thr();

endpackage

@@ rtl/dominant_edge_direction_core.sv @@
// ----------------------------------------------------------------------------
// dominant_edge_direction_core
// Length-weighted edge orientation histogram of a closed polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per polygon vertex, tdata = {y, x}, tlast marks
//   the final vertex. The block closes the polygon back to the first vertex.
//   Master stream: one beat per polygon, tdata = {peak_weight, main_angle}.
// Sequence:
//   The first vertex of a polygon is only stored; s_tready stays high.
//   After a beat with a nonzero edge s_tready stays low through load,
//   prep, 48 CORDIC iterations with the integer sqrt alongside, scale,
//   7 degree search steps, histogram read and write.
//   A zero-length edge holds it low through load and prep only.
//   On tlast the closing edge follows the same way, then a scan of the
//   180 bins through the single read port, the output state, which waits
//   for a free output register; m_tvalid rises in the cycle after the load.
// Reset: histogram valid bits, vertex state and the output valid flag clear
//   at once; no sweep over the memory is needed.
// Stall: the result sits in an output register; new vertices are taken
//   while it waits, and only a second result stalls until it is taken.
// ----------------------------------------------------------------------------
module dominant_edge_direction_core
#(
    parameter int COORD_WIDTH  = 12,
    parameter int WEIGHT_WIDTH = 24
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,  // vertex_x, vertex_y
    input  logic                                    s_tlast,  // last_vertex
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((8+WEIGHT_WIDTH+7)/8)*8-1:0]     m_tdata   // main_angle, peak_weight
);

    localparam int MW = ((8 + WEIGHT_WIDTH + 7) / 8) * 8;

    ded_pkg::ded_cmd_t          cmd;
    ded_pkg::ded_stat_t         stat;
    logic [ded_pkg::BIN_W-1:0]  angle;
    logic [WEIGHT_WIDTH-1:0]    weight;

    ded_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ded_datapath
    #(
        .COORD_WIDTH  (COORD_WIDTH),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_x       (s_tdata[COORD_WIDTH-1:0]),
        .in_y       (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_angle  (angle),
        .out_weight (weight)
    );

    assign m_tdata = MW'({weight, angle});

endmodule

@@ rtl/ded_ctrl.sv @@
// ----------------------------------------------------------------------------
// ded_ctrl
// Sequencer: vertex intake, per-edge CORDIC/sqrt steps, histogram scan.
// ----------------------------------------------------------------------------
module ded_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    input  ded_pkg::ded_stat_t stat,
    output ded_pkg::ded_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_LOAD  = 10'b00_0000_0010,
        ST_PREP  = 10'b00_0000_0100,
        ST_ITER  = 10'b00_0000_1000,
        ST_SCALE = 10'b00_0001_0000,
        ST_SRCH  = 10'b00_0010_0000,
        ST_RD    = 10'b00_0100_0000,
        ST_WR    = 10'b00_1000_0000,
        ST_SCAN  = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [ded_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      close_reg, close_next;

    // where to go once an edge is binned or found to be zero-length
    state_t                    after_state;
    logic                      after_close;

    always_comb
    begin
        if (!close_reg && stat.last) begin
            after_state = ST_LOAD;
            after_close = 1'b1;
        end else if (stat.last) begin
            after_state = ST_SCAN;
            after_close = close_reg;
        end else begin
            after_state = ST_IDLE;
            after_close = close_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        close_next = close_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    close_next = 1'b0;
                    cnt_next   = '0;
                    if (stat.have_vertex) begin
                        state_next = ST_LOAD;
                    end else if (s_tlast) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cnt_next = '0;
                if (stat.zero_edge) begin
                    state_next = after_state;
                    close_next = after_close;
                end else begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (cnt_reg == ded_pkg::CNT_W'(ded_pkg::CORDIC_STEPS - 1)) begin
                    state_next = ST_SCALE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_SRCH;
                cnt_next   = ded_pkg::CNT_W'(ded_pkg::DEG_W - 1);
            end
            ST_SRCH:
            begin
                if (cnt_reg == '0) begin
                    state_next = ST_RD;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                state_next = after_state;
                close_next = after_close;
                cnt_next   = '0;
            end
            ST_SCAN:
            begin
                if (cnt_reg == ded_pkg::CNT_W'(ded_pkg::HIST_BINS)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            close_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            close_reg <= close_next;
        end
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.accept    = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.load_edge = (state_reg == ST_LOAD);
    assign cmd.sel_close = close_reg;
    assign cmd.prep      = (state_reg == ST_PREP);
    assign cmd.iter      = (state_reg == ST_ITER);
    assign cmd.scale     = (state_reg == ST_SCALE);
    assign cmd.search    = (state_reg == ST_SRCH);
    assign cmd.bin_rd    = (state_reg == ST_RD);
    assign cmd.acc_wr    = (state_reg == ST_WR);
    assign cmd.scan      = (state_reg == ST_SCAN);
    assign cmd.out_load  = (state_reg == ST_OUT) && stat.out_free;
    assign cmd.cnt       = cnt_reg;

endmodule

@@ rtl/ded_datapath.sv @@
// ----------------------------------------------------------------------------
// ded_datapath
// Vertex registers, CORDIC vectoring, integer sqrt, degree search, histogram.
// ----------------------------------------------------------------------------
module ded_datapath
#(
    parameter int COORD_WIDTH  = 12,
    parameter int WEIGHT_WIDTH = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ded_pkg::ded_cmd_t       cmd,
    output ded_pkg::ded_stat_t      stat,
    input  logic [COORD_WIDTH-1:0]  in_x,
    input  logic [COORD_WIDTH-1:0]  in_y,
    input  logic                    in_last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ded_pkg::BIN_W-1:0] out_angle,
    output logic [WEIGHT_WIDTH-1:0] out_weight
);

    localparam int C   = COORD_WIDTH;
    localparam int VW  = C + ded_pkg::VEC_FRAC + 3;
    localparam int NW  = 2 * C + 2;
    localparam int SQ  = C + 1;
    localparam int LW  = C + 1;
    localparam int SW  = WEIGHT_WIDTH + C + 2;
    localparam int ZW  = ded_pkg::ZW;
    localparam int TW  = ded_pkg::TW;
    localparam int BW  = ded_pkg::BIN_W;
    localparam int DW  = ded_pkg::DEG_W;

    // vertex bookkeeping
    logic [C-1:0] cur_x_reg, cur_y_reg, first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic         have_reg, last_reg;

    logic signed [C:0]  u_reg, v_reg;
    logic signed [C:0]  un, vn;
    logic               neg;
    logic [C-1:0]       from_x, from_y, to_x, to_y, a_mag;
    logic               mirror_reg;

    // CORDIC
    logic signed [VW-1:0] x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0] z_reg, atan_v;
    logic [ded_pkg::STEP_W-1:0] step;

    // integer square root
    logic [NW-1:0]   n_reg;
    logic [C+1:0]    rem_reg;
    logic [C+3:0]    rem2, trial;
    logic [LW-1:0]   root_reg;

    // degree search
    logic [TW-1:0]   p90_reg, zx;
    logic [DW-1:0]   deg_reg, cand;
    logic [BW-1:0]   bin_c, bin_reg;

    // histogram
    logic [WEIGHT_WIDTH-1:0] hist_mem [ded_pkg::HIST_BINS];
    logic [ded_pkg::HIST_BINS-1:0] hvalid_reg;
    logic [WEIGHT_WIDTH-1:0] rd_data_reg, rd_w;
    logic                    rd_vld_reg;
    logic [BW-1:0]           rd_addr;
    logic                    rd_en;
    logic [SW-1:0]           sum_w;
    logic [WEIGHT_WIDTH-1:0] sat_w;

    // scan
    logic [WEIGHT_WIDTH-1:0] best_reg;
    logic [BW-1:0]           best_idx_reg;
    logic                    out_valid_reg;
    logic [BW-1:0]           out_angle_reg;
    logic [WEIGHT_WIDTH-1:0] out_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            have_reg <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                have_reg <= 1'b1;
                last_reg <= in_last;
            end else if (cmd.out_load) begin
                have_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            cur_x_reg <= in_x;
            cur_y_reg <= in_y;
            if (!have_reg) begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
                prev_x_reg  <= in_x;
                prev_y_reg  <= in_y;
            end
        end else if (cmd.load_edge && !cmd.sel_close) begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
    end

    // edge endpoints
    assign from_x = cmd.sel_close ? cur_x_reg   : prev_x_reg;
    assign from_y = cmd.sel_close ? cur_y_reg   : prev_y_reg;
    assign to_x   = cmd.sel_close ? first_x_reg : cur_x_reg;
    assign to_y   = cmd.sel_close ? first_y_reg : cur_y_reg;

    // fold into the upper half plane, then mirror into the first quadrant
    assign neg   = v_reg[C] || ((v_reg == '0) && u_reg[C]);
    assign un    = neg ? -u_reg : u_reg;
    assign vn    = neg ? -v_reg : v_reg;
    assign a_mag = un[C] ? C'(-un) : un[C-1:0];

    assign step   = cmd.cnt[ded_pkg::STEP_W-1:0];
    assign xs     = x_reg >>> step;
    assign ys     = y_reg >>> step;
    assign atan_v = $signed(ded_pkg::ATAN_TAB[step][ZW-1:0]);

    assign rem2  = {rem_reg, n_reg[NW-1:NW-2]};
    assign trial = {1'b0, root_reg, 2'b01};

    assign zx   = z_reg[ZW-1] ? '0 : TW'(z_reg[ZW-2:0]);
    assign cand = deg_reg | (DW'(1) << cmd.cnt[2:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_edge) begin
            u_reg <= $signed({1'b0, to_x}) - $signed({1'b0, from_x});
            v_reg <= $signed({1'b0, from_y}) - $signed({1'b0, to_y});
        end
        if (cmd.prep) begin
            mirror_reg <= un[C];
            x_reg      <= $signed({{(VW-C-ded_pkg::VEC_FRAC){1'b0}}, a_mag,
                                   {ded_pkg::VEC_FRAC{1'b0}}});
            y_reg      <= $signed({{(VW-C-ded_pkg::VEC_FRAC-1){1'b0}}, vn,
                                   {ded_pkg::VEC_FRAC{1'b0}}});
            z_reg      <= '0;
            n_reg      <= NW'(u_reg * u_reg) + NW'(v_reg * v_reg);
            rem_reg    <= '0;
            root_reg   <= '0;
            deg_reg    <= '0;
        end
        if (cmd.iter) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_v;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_v;
            end
            if (cmd.cnt < ded_pkg::CNT_W'(SQ)) begin
                n_reg <= n_reg << 2;
                if (rem2 >= trial) begin
                    rem_reg  <= (C+2)'(rem2 - trial);
                    root_reg <= {root_reg[LW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem2[C+1:0];
                    root_reg <= {root_reg[LW-2:0], 1'b0};
                end
            end
        end
        if (cmd.scale) begin
            p90_reg <= (zx << 6) + (zx << 4) + (zx << 3) + (zx << 1);
        end
        if (cmd.search) begin
            if (p90_reg >= ded_pkg::THR_TAB[cand]) begin
                deg_reg <= cand;
            end
        end
        if (cmd.bin_rd) begin
            bin_reg <= bin_c;
        end
    end

    always_comb
    begin
        if (mirror_reg && (deg_reg != '0)) begin
            bin_c = BW'(ded_pkg::HALF_TURN) - BW'(deg_reg);
        end else begin
            bin_c = BW'(deg_reg);
        end
    end

    // histogram memory, registered read
    assign rd_en   = cmd.bin_rd || (cmd.scan && (cmd.cnt < ded_pkg::CNT_W'(ded_pkg::HIST_BINS)));
    assign rd_addr = cmd.bin_rd ? bin_c : cmd.cnt;
    assign rd_w    = rd_vld_reg ? rd_data_reg : '0;
    assign sum_w   = SW'(rd_w) + SW'(root_reg);
    assign sat_w   = (sum_w > SW'({WEIGHT_WIDTH{1'b1}})) ? '1 : sum_w[WEIGHT_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
            rd_vld_reg  <= hvalid_reg[rd_addr];
        end
        if (cmd.acc_wr) begin
            hist_mem[bin_reg] <= sat_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hvalid_reg <= '0;
        end else if (cmd.out_load) begin
            hvalid_reg <= '0;
        end else if (cmd.acc_wr) begin
            hvalid_reg[bin_reg] <= 1'b1;
        end
    end

    // running maximum, strict compare keeps the lowest bin on ties
    always_ff @(posedge clk)
    begin
        if (cmd.scan) begin
            if (cmd.cnt == '0) begin
                best_reg     <= '0;
                best_idx_reg <= '0;
            end else if (rd_w > best_reg) begin
                best_reg     <= rd_w;
                best_idx_reg <= cmd.cnt - 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_angle_reg  <= best_idx_reg;
            out_weight_reg <= best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_angle  = out_angle_reg;
    assign out_weight = out_weight_reg;

    assign stat.have_vertex = have_reg;
    assign stat.last        = last_reg;
    assign stat.zero_edge   = (u_reg == '0) && (v_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

endmodule

@@ rtl/ded_checker.sv @@
// ----------------------------------------------------------------------------
// ded_checker
// Port-level checks on the edge direction core, bound to the top level.
// ----------------------------------------------------------------------------
`include "dominant_edge_direction_core_assert.svh"

module ded_checker
#(
    parameter int COORD_WIDTH  = 12,
    parameter int WEIGHT_WIDTH = 24
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input logic                                s_tlast,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((8+WEIGHT_WIDTH+7)/8)*8-1:0] m_tdata
);

    logic in_beat;
    logic in_wait;

    assign in_beat = s_tvalid && s_tready;
    assign in_wait = s_tvalid && !s_tready;

    `DED_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `DED_ASSERT_IMP(a_angle_range, m_tvalid, m_tdata[7:0] < 8'd180)
    `DED_ASSERT_NXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata))
    `DED_ASSERT_NXT(a_busy_after_last, in_beat && s_tlast, !s_tready)
    `DED_ASSERT_NXT(a_in_hold, in_wait, s_tvalid && $stable(s_tdata) && $stable(s_tlast))

endmodule

bind dominant_edge_direction_core ded_checker
#(
    .COORD_WIDTH  (COORD_WIDTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
)
u_ded_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
